// ----- hw/rtl/tprt_pkg.sv -----
// ----------------------------------------------------------------------------
// tprt_pkg: shared types and constants for the stream rate tracker
// Table geometry, word layouts on both channels, queue word and the
// request/response bundles of the rate divider.
// ----------------------------------------------------------------------------
package tprt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int AMOUNT_BITS   = 48;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int ID_W          = 13;
    localparam int PAYLOAD_W     = 16;
    localparam int ELAPSED_W     = 32;
    localparam int SLOT_OUT_W    = 3;
    localparam int RATE_W        = 52;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int DIV_CNT_W     = $clog2(AMOUNT_BITS + 1);
    localparam int PROD_W        = AMOUNT_BITS + 10;

    localparam logic [SLOT_W-1:0]      LAST_SLOT  = SLOT_W'(TABLE_ENTRIES - 1);
    localparam logic [AMOUNT_BITS-1:0] AMOUNT_MAX = '1;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    typedef struct packed {
        logic                 cmd;
        logic [ID_W-1:0]      stream_id;
        logic [PAYLOAD_W-1:0] payload_bytes;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       entry_id;
        logic [RATE_W-1:0]     rate;
        logic                  entry_valid;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        op_t                  op;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
        logic [ELAPSED_W-1:0] elapsed;
    } job_t;

    typedef struct packed {
        logic                   start;
        logic [AMOUNT_BITS-1:0] amount;
        logic [ELAPSED_W-1:0]   elapsed;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [AMOUNT_BITS-1:0] quot;
    } div_rsp_t;

endpackage

// ----- hw/rtl/tprt_front.sv -----
// ----------------------------------------------------------------------------
// tprt_front: input stage
// Registers each accepted word, decodes the command and drops the fields
// the command does not use, then hands the job to the queue.
// ----------------------------------------------------------------------------
module tprt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tprt_pkg::in_word_t in_word,
    output logic               push,
    output tprt_pkg::job_t     push_job,
    input  logic               push_ready
);
    import tprt_pkg::*;

    logic hold_valid_reg;
    job_t job_reg;
    job_t job_next;

    // decode: adds keep id and payload, reports keep elapsed time
    always_comb
    begin
        job_next = '0;
        if (in_word.cmd)
        begin
            job_next.op      = OP_REPORT;
            job_next.elapsed = in_word.elapsed_ms;
        end
        else
        begin
            job_next.op      = OP_ADD;
            job_next.id      = in_word.stream_id;
            job_next.payload = in_word.payload_bytes;
        end
    end

    assign push     = hold_valid_reg;
    assign push_job = job_reg;
    assign in_ready = !hold_valid_reg || push_ready;

    // holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- hw/rtl/tprt_fifo.sv -----
// ----------------------------------------------------------------------------
// tprt_fifo: job queue
// Short queue between the input stage and the table engine.
// ----------------------------------------------------------------------------
module tprt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tprt_pkg::job_t push_job,
    output logic           push_ready,
    input  logic           pop,
    output tprt_pkg::job_t pop_job,
    output logic           pop_valid
);
    import tprt_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/tprt_div.sv -----
// ----------------------------------------------------------------------------
// tprt_div: rate divider
// Computes floor(floor(amount*1000/1024) / elapsed), one quotient bit
// per cycle (restoring division).
// ----------------------------------------------------------------------------
module tprt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tprt_pkg::div_req_t req,
    output tprt_pkg::div_rsp_t rsp
);
    import tprt_pkg::*;

    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   done_reg;
    logic [AMOUNT_BITS-1:0] quo_reg;
    logic [ELAPSED_W-1:0]   rem_reg;
    logic [ELAPSED_W-1:0]   den_reg;
    logic [PROD_W-1:0]      amt_ext;
    logic [PROD_W-1:0]      prod;
    logic [ELAPSED_W:0]     rem_sh;
    logic [ELAPSED_W:0]     diff;
    logic                   ge;

    // amount*1000 = amount*1024 - amount*16 - amount*8
    assign amt_ext = PROD_W'(req.amount);
    assign prod    = (amt_ext << 10) - (amt_ext << 4) - (amt_ext << 3);

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[AMOUNT_BITS-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DIV_CNT_W'(AMOUNT_BITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= prod[PROD_W-1:10];
            rem_reg <= '0;
            den_reg <= req.elapsed;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[AMOUNT_BITS-2:0], ge};
            rem_reg <= ge ? diff[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/tprt_back.sv -----
// ----------------------------------------------------------------------------
// tprt_back: table engine
// Holds the sorted table, runs adds (lookup, update, bubble up one slot
// per cycle) and reports (one slot per result, rate from the divider).
// ----------------------------------------------------------------------------
module tprt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tprt_pkg::job_t      q_job,
    output logic                q_pop,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output tprt_pkg::div_req_t  div_req,
    input  tprt_pkg::div_rsp_t  div_rsp,
    output logic                out_valid,
    input  logic                out_ready,
    output tprt_pkg::out_word_t out_word
);
    import tprt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_SCAN,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      pos_reg;
    logic [SLOT_W-1:0]      ridx_reg;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic                   empty_reg;
    logic                   use_bytes_reg;
    logic                   out_valid_reg;
    out_word_t              out_word_reg;
    logic [ID_W-1:0]        id_reg  [TABLE_ENTRIES];
    logic [AMOUNT_BITS-1:0] amt_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] used_reg;

    logic [TABLE_ENTRIES-1:0] match;
    logic                     hit;
    logic [SLOT_W-1:0]        hidx;
    logic [AMOUNT_BITS:0]     sum;
    logic [AMOUNT_BITS-1:0]   sum_sat;
    logic [TABLE_ENTRIES-1:0] lt;
    logic                     swap;
    logic [TABLE_ENTRIES-1:0] above;
    logic                     is_last;
    logic                     out_free;
    logic [RATE_W-1:0]        rate_scaled;

    // lookup of the incoming id
    always_comb
    begin
        hidx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = used_reg[i] && (id_reg[i] == q_job.id);
            if (match[i])
            begin
                hidx = SLOT_W'(i);
            end
        end
        hit = |match;
    end

    // saturating accumulate
    assign sum     = {1'b0, amt_reg[hidx]} + (AMOUNT_BITS + 1)'(q_job.payload);
    assign sum_sat = sum[AMOUNT_BITS] ? AMOUNT_MAX : sum[AMOUNT_BITS-1:0];

    // neighbor compares for the bubble step
    always_comb
    begin
        lt[0] = 1'b0;
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            lt[i] = amt_reg[i-1] < amt_reg[i];
        end
    end
    assign swap = (state_reg == ST_MOVE) && (pos_reg != '0) && lt[pos_reg];

    // used slots after the one being reported
    always_comb
    begin
        for (int j = 0; j < TABLE_ENTRIES; j++)
        begin
            above[j] = used_reg[j] && (SLOT_W'(j) > ridx_reg);
        end
    end
    assign is_last = empty_reg || (above == '0);

    assign rate_scaled = use_bytes_reg ? RATE_W'(div_rsp.quot)
                                       : (RATE_W'(div_rsp.quot) << 3);

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign div_req.start   = (state_reg == ST_SCAN) && used_reg[ridx_reg]
                             && (elapsed_reg != '0);
    assign div_req.amount  = amt_reg[ridx_reg];
    assign div_req.elapsed = elapsed_reg;

    // sequencer, table and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ridx_reg      <= '0;
            elapsed_reg   <= '0;
            rate_reg      <= '0;
            empty_reg     <= 1'b0;
            use_bytes_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            used_reg      <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                id_reg[i]  <= '0;
                amt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                use_bytes_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_job.op == OP_REPORT)
                        begin
                            elapsed_reg <= q_job.elapsed;
                            ridx_reg    <= '0;
                            if (used_reg == '0)
                            begin
                                empty_reg <= 1'b1;
                                rate_reg  <= '0;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                empty_reg <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                        end
                        else if (hit)
                        begin
                            amt_reg[hidx] <= sum_sat;
                            pos_reg       <= hidx;
                            state_reg     <= ST_MOVE;
                        end
                        else if (amt_reg[LAST_SLOT] < AMOUNT_BITS'(q_job.payload))
                        begin
                            id_reg[LAST_SLOT]   <= q_job.id;
                            used_reg[LAST_SLOT] <= 1'b1;
                            amt_reg[LAST_SLOT]  <= AMOUNT_BITS'(q_job.payload);
                            pos_reg             <= LAST_SLOT;
                            state_reg           <= ST_MOVE;
                        end
                    end
                end

                ST_MOVE:
                begin
                    if (swap)
                    begin
                        // exchange slot pos with the one above it
                        for (int i = 1; i < TABLE_ENTRIES; i++)
                        begin
                            if (SLOT_W'(i) == pos_reg)
                            begin
                                id_reg[i]     <= id_reg[i-1];
                                amt_reg[i]    <= amt_reg[i-1];
                                used_reg[i]   <= used_reg[i-1];
                                id_reg[i-1]   <= id_reg[i];
                                amt_reg[i-1]  <= amt_reg[i];
                                used_reg[i-1] <= used_reg[i];
                            end
                        end
                        pos_reg <= pos_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_SCAN:
                begin
                    if (used_reg[ridx_reg])
                    begin
                        if (elapsed_reg == '0)
                        begin
                            rate_reg  <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_WAIT;
                        end
                    end
                    else
                    begin
                        ridx_reg <= ridx_reg + 1'b1;
                    end
                end

                ST_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg  <= rate_scaled;
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_word_reg.slot        <= empty_reg ? '0 : SLOT_OUT_W'(ridx_reg);
                        out_word_reg.entry_id    <= empty_reg ? '0 : id_reg[ridx_reg];
                        out_word_reg.rate        <= rate_reg;
                        out_word_reg.entry_valid <= !empty_reg;
                        out_word_reg.last        <= is_last;
                        if (is_last)
                        begin
                            // report done: empty the table
                            used_reg <= '0;
                            for (int i = 0; i < TABLE_ENTRIES; i++)
                            begin
                                id_reg[i]  <= '0;
                                amt_reg[i] <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ridx_reg  <= ridx_reg + 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/top_pid_rate_tracker_top.sv -----
// ----------------------------------------------------------------------------
// top_pid_rate_tracker_top: stream rate tracker
// Sorted table of the most active stream ids with a per-slot rate report.
//
//   channel   signals                         direction
//   in        in_valid/in_ready/in_word       word in, add or report
//   out       out_valid/out_ready/out_word    word out, one per reported slot
//   cfg       cfg_we/cfg_wdata                use_bytes write, no wait
//
// An add that leaves the table as it is ends in the idle state; one that
// changes it then bubbles the entry up, slot by slot, in the move state.
// A report runs the bit-serial divider once per used slot (not at zero
// elapsed time, where the rate is 0) and gives a single word for an empty table.
// The input stage and a 2-word queue keep taking words, until both are
// full, while the engine works or the output is stalled. Reset empties
// the table, use_bytes is 1.
// ----------------------------------------------------------------------------
module top_pid_rate_tracker_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tprt_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output tprt_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import tprt_pkg::*;

    logic     push;
    job_t     push_job;
    logic     push_ready;
    logic     q_pop;
    job_t     q_job;
    logic     q_valid;
    div_req_t div_req;
    div_rsp_t div_rsp;

    tprt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    tprt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_job    (q_job),
        .pop_valid  (q_valid)
    );

    tprt_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    tprt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // an empty-table word closes the report and carries no rate
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.entry_valid |-> out_word.last && out_word.rate == '0)
        else $error("empty report word not final or nonzero rate");

    // the divider never finishes right after it starts
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider done too early");

    // the engine only pops a queue that holds a job
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
